/* hdl/ssim_pkg.sv */
// Package for the sorted set block: beat types, command codes, cell link type,
// cell control type and sequencer states. No dependencies.
package ssim_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int COUNT_OUT_W  = 7;

    localparam logic [1:0] CMD_MEMBER = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]                cmd;
        logic signed [VALUE_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic                   success;
        logic                   full_reject;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_out_beat;

    // What a cell shows its neighbors
    typedef struct packed {
        logic                      valid;
        logic                      lt;
        logic signed [VALUE_W-1:0] value;
    } t_link;

    // Broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

endpackage

/* hdl/ssim_cell.sv */
// One slot of the sorted chain: holds a key, compares it with the probe and
// shifts to or from its neighbors. Depends on ssim_pkg.
module ssim_cell import ssim_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_ctl                 i_ctl,
    input  logic signed [VALUE_W-1:0] i_probe,
    input  t_link                     i_left,
    input  t_link                     i_right,
    output t_link                     o_link,
    output logic                      o_eq
);

    logic                      r_valid, n_valid;
    logic                      r_lt, n_lt;
    logic                      r_eq, n_eq;
    logic signed [VALUE_W-1:0] r_value, n_value;

    always_comb begin
        n_valid = r_valid;
        n_lt    = r_lt;
        n_eq    = r_eq;
        n_value = r_value;
        if (i_ctl.cmp) begin
            n_lt = r_valid && (r_value < i_probe);
            n_eq = r_valid && (r_value == i_probe);
        end
        if (i_ctl.ins && !r_lt) begin
            n_value = i_left.lt ? i_probe : i_left.value;
            n_valid = r_valid | i_left.valid;
        end
        if (i_ctl.del && !r_lt) begin
            n_value = i_right.value;
            n_valid = i_right.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lt    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_lt    <= n_lt;
            r_eq    <= n_eq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link = '{valid: r_valid, lt: r_lt, value: r_value};
    assign o_eq   = r_eq;

endmodule

/* hdl/sorted_set_insert_delete_member.sv */
// Sorted set of distinct signed 32-bit keys held in a chain of CAPACITY cells,
// ascending from cell 0. A beat is accepted in ST_IDLE; in ST_CMP every cell
// tests its key against the probe in parallel; in ST_UPD the cells shift up
// (insert) or down (delete) by one and the result beat is loaded, once the
// output register is free or not stalled. The next beat is taken only after
// the result is in the output register, so no new beat is accepted before
// the last one is through. Depends on ssim_pkg and ssim_cell.
module sorted_set_insert_delete_member import ssim_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state          r_state, n_state;
    t_in_beat        r_beat;
    logic [CNT_W-1:0] r_count, n_count;
    logic            r_out_valid;
    t_out_beat       r_out, n_out;

    t_cell_ctl       w_ctl;
    logic            w_in_acc, w_apply, w_found, w_full, w_ins, w_del;
    t_link           w_link [CAPACITY];
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_valid;
    logic [31:0]     w_cnt_ext;

    assign w_in_acc = i_in_valid && !o_in_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_CMP;
            ST_CMP:  n_state = ST_UPD;
            ST_UPD:  if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_stall = 1'b1;
        w_apply    = 1'b0;
        case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_CMP:  o_in_stall = 1'b1;
            ST_UPD:  w_apply = !r_out_valid || !i_out_stall;
            default: o_in_stall = 1'b1;
        endcase
    end

    assign w_found = |w_eq;
    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_ins   = w_apply && (r_beat.cmd == CMD_INSERT) && !w_found && !w_full;
    assign w_del   = w_apply && (r_beat.cmd == CMD_DELETE) && w_found;
    assign w_ctl   = '{cmp: (r_state == ST_CMP), ins: w_ins, del: w_del};

    always_comb begin
        n_count = r_count;
        if (w_ins) n_count = r_count + CNT_W'(1);
        if (w_del) n_count = r_count - CNT_W'(1);
    end

    assign w_cnt_ext = 32'(n_count);

    always_comb begin
        n_out             = r_out;
        n_out.success     = w_ins || w_del ||
                            ((r_beat.cmd == CMD_MEMBER) && w_found);
        n_out.full_reject = (r_beat.cmd == CMD_INSERT) && !w_found && w_full;
        n_out.entry_count = w_cnt_ext[COUNT_OUT_W-1:0];
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_link w_left, w_right;
            if (gi == 0) begin : g_first
                assign w_left = '{valid: 1'b1, lt: 1'b1, value: '0};
            end else begin : g_mid_l
                assign w_left = w_link[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_right = '{valid: 1'b0, lt: 1'b0, value: '0};
            end else begin : g_mid_r
                assign w_right = w_link[gi+1];
            end
            ssim_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_probe (r_beat.value),
                .i_left  (w_left),
                .i_right (w_right),
                .o_link  (w_link[gi]),
                .o_eq    (w_eq[gi])
            );
            assign w_valid[gi] = w_link[gi].valid;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_apply) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) r_beat <= i_in_data;
        if (w_apply) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_accept_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_CMP))
        else $error("accepted beat did not start a compare");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("cell valid bits disagree with entry count");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the count");

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + CAPACITY'(1))) == '0)
        else $error("valid cells are not a prefix of the chain");

endmodule
